### design/pareto_minimal_set_filter_macros.svh
// Assertion macros used by the RTL of the Pareto set filter.
`ifndef PARETO_MINIMAL_SET_FILTER_MACROS_SVH
`define PARETO_MINIMAL_SET_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
`define PMSF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pmsf assertion failed");
`define PMSF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pmsf assertion failed");
`else
`define PMSF_ASSERT(label, clk, rst_n, prop)
`define PMSF_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### design/pmsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pmsf_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DIM_BITS_DEF = 8;

endpackage

`default_nettype wire

### design/pmsf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pmsf_in_if #(
  parameter int DIM_BITS = pmsf_pkg::DIM_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] item_width;
  logic [DIM_BITS-1:0] item_height;
  logic                end_of_list;

  modport source (output valid, output item_width, output item_height,
                  output end_of_list, input ready);
  modport sink (input valid, input item_width, input item_height,
                input end_of_list, output ready);
endinterface

`default_nettype wire

### design/pmsf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pmsf_out_if #(
  parameter int DIM_BITS = pmsf_pkg::DIM_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] frontier_width;
  logic [DIM_BITS-1:0] frontier_height;
  logic                last_entry;
  logic                overflow;

  modport source (output valid, output frontier_width, output frontier_height,
                  output last_entry, output overflow, input ready);
  modport sink (input valid, input frontier_width, input frontier_height,
                input last_entry, input overflow, output ready);
endinterface

`default_nettype wire

### design/pareto_minimal_set_filter.sv
// Pareto-minimal set filter for (width, height) pairs.
// The input channel in_chan takes one pair per transfer; end_of_list marks
// the final pair of a list. The result channel out_chan gives the surviving
// pairs of that list in order of first appearance, last_entry on the final
// one, and the sticky overflow flag on every result.
// Each input pair walks the stored set once through a single-port-read
// pair memory, so the block takes no new pair until that walk is done;
// in_chan.ready is high only while the block is idle.
// After the final pair has been handled the readout starts; each result is
// read from the store only after the previous one has been taken, and a
// stalled receiver holds the result in the output register while the
// readout waits.
// Reset empties the store and clears the overflow flag, which otherwise
// survives readout. A pair that must be stored into a full store is
// dropped and sets the overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module pareto_minimal_set_filter #(
  parameter int CAPACITY = pmsf_pkg::CAPACITY_DEF,
  parameter int DIM_BITS = pmsf_pkg::DIM_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  pmsf_in_if.sink     in_chan,
  pmsf_out_if.source  out_chan
);

`include "pareto_minimal_set_filter_macros.svh"

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = 2 * DIM_BITS;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SCAN      = 3'd1;
  localparam logic [2:0] ST_FINISH    = 3'd2;
  localparam logic [2:0] ST_EMIT_RD   = 3'd3;
  localparam logic [2:0] ST_EMIT_LOAD = 3'd4;
  localparam logic [2:0] ST_EMIT_OUT  = 3'd5;

  logic [PW-1:0] pair_mem [CAPACITY];

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       scan_idx_r, scan_idx_nxt;
  logic [CW-1:0]       kept_r, kept_nxt;
  logic [CW-1:0]       em_idx_r, em_idx_nxt;
  logic                drop_r, drop_nxt;
  logic                ovf_r, ovf_nxt;
  logic                rd_vld_r;
  logic [DIM_BITS-1:0] cur_w_r, cur_w_nxt;
  logic [DIM_BITS-1:0] cur_h_r, cur_h_nxt;
  logic                eol_r, eol_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DIM_BITS-1:0] out_w_r, out_w_nxt;
  logic [DIM_BITS-1:0] out_h_r, out_h_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [PW-1:0]       rd_data_r;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [PW-1:0]       wr_data;
  logic [DIM_BITS-1:0] s_w, s_h;
  logic                dom, covers;

  assign s_w    = rd_data_r[PW-1:DIM_BITS];
  assign s_h    = rd_data_r[DIM_BITS-1:0];
  assign dom    = (s_w <= cur_w_r) && (s_h <= cur_h_r);
  assign covers = (cur_w_r <= s_w) && (cur_h_r <= s_h);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    kept_nxt      = kept_r;
    em_idx_nxt    = em_idx_r;
    drop_nxt      = drop_r;
    ovf_nxt       = ovf_r;
    cur_w_nxt     = cur_w_r;
    cur_h_nxt     = cur_h_r;
    eol_nxt       = eol_r;
    out_valid_nxt = out_valid_r;
    out_w_nxt     = out_w_r;
    out_h_nxt     = out_h_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    rd_en         = 1'b0;
    rd_addr       = scan_idx_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = kept_r[AW-1:0];
    wr_data       = rd_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          cur_w_nxt    = in_chan.item_width;
          cur_h_nxt    = in_chan.item_height;
          eol_nxt      = in_chan.end_of_list;
          scan_idx_nxt = '0;
          kept_nxt     = '0;
          drop_nxt     = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = (scan_idx_r < count_r);
        if (rd_en) begin
          scan_idx_nxt = scan_idx_r + CW'(1);
        end
        if (rd_vld_r) begin
          // An equal or smaller stored pair stays and drops the new one.
          if (dom || !covers) begin
            wr_en    = 1'b1;
            kept_nxt = kept_r + CW'(1);
          end
          if (dom) begin
            drop_nxt = 1'b1;
          end
        end
        if (!rd_en && !rd_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        count_nxt = kept_r;
        if (!drop_r) begin
          if (kept_r == CW'(CAPACITY)) begin
            ovf_nxt = 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_data   = {cur_w_r, cur_h_r};
            count_nxt = kept_r + CW'(1);
          end
        end
        em_idx_nxt = '0;
        state_nxt  = eol_r ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = em_idx_r[AW-1:0];
        state_nxt = ST_EMIT_LOAD;
      end
      ST_EMIT_LOAD: begin
        out_valid_nxt = 1'b1;
        out_w_nxt     = s_w;
        out_h_nxt     = s_h;
        out_last_nxt  = (em_idx_r + CW'(1)) == count_r;
        out_ovf_nxt   = ovf_r;
        state_nxt     = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            em_idx_nxt = em_idx_r + CW'(1);
            state_nxt  = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pair_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= pair_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_idx_r  <= '0;
      kept_r      <= '0;
      em_idx_r    <= '0;
      drop_r      <= 1'b0;
      ovf_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      kept_r      <= kept_nxt;
      em_idx_r    <= em_idx_nxt;
      drop_r      <= drop_nxt;
      ovf_r       <= ovf_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_w_r    <= cur_w_nxt;
    cur_h_r    <= cur_h_nxt;
    eol_r      <= eol_nxt;
    out_w_r    <= out_w_nxt;
    out_h_r    <= out_h_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_chan.ready            = (state_r == ST_IDLE);
  assign out_chan.valid           = out_valid_r;
  assign out_chan.frontier_width  = out_w_r;
  assign out_chan.frontier_height = out_h_r;
  assign out_chan.last_entry      = out_last_r;
  assign out_chan.overflow        = out_ovf_r;

  // Compaction never writes ahead of the entry being read.
  `PMSF_ASSERT(a_kept_behind_scan, clk, rst_n,
    (state_r == ST_SCAN) |-> (kept_r <= scan_idx_r))
  `PMSF_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY))
  `PMSF_ASSERT(a_out_only_in_emit, clk, rst_n,
    out_valid_r |-> (state_r == ST_EMIT_OUT))
  `PMSF_ASSERT(a_overflow_sticky, clk, rst_n, ovf_r |=> ovf_r)
  `PMSF_ASSERT(a_last_empties, clk, rst_n,
    (out_valid_r && out_chan.ready && out_last_r) |=> (count_r == '0))

endmodule

`default_nettype wire
